@@ hdl/ptzfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptzfd_pkg
// Shared types and constants of the PTZ joystick frame decoder.
// ----------------------------------------------------------------------------
package ptzfd_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int ACT_W      = 4;
   localparam int LEN_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Default frame limits (sync byte included)
   localparam int DEF_MAX_FRAME = 16;
   localparam int DEF_MIN_FRAME = 7;

   // Register map: word index taken from paddr[2]
   localparam logic REG_ZOOM_SPEED = 1'b0;
   localparam logic [BYTE_W-1:0] ZOOM_SPEED_RESET = 8'h05;

   // Frame and command byte codes
   localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
   localparam logic [BYTE_W-1:0] CMD_NONE      = 8'h00;
   localparam logic [BYTE_W-1:0] CMD2_ZOOM_TEL = 8'h20;
   localparam logic [BYTE_W-1:0] CMD2_ZOOM_WID = 8'h40;
   localparam logic [BYTE_W-1:0] CMD2_FOC_FAR  = 8'h80;
   localparam logic [BYTE_W-1:0] CMD1_FOC_NEAR = 8'h01;
   localparam logic [BYTE_W-1:0] CMD1_IRIS_UP  = 8'h02;
   localparam logic [BYTE_W-1:0] CMD1_IRIS_DN  = 8'h04;

   typedef enum logic [ACT_W-1:0] {
      ACT_TOUCH      = 4'd0,
      ACT_OVL_ON     = 4'd1,
      ACT_OVL_OFF    = 4'd2,
      ACT_ZOOM_TELE  = 4'd3,
      ACT_ZOOM_WIDE  = 4'd4,
      ACT_ZOOM_STOP  = 4'd5,
      ACT_FOCUS_NEAR = 4'd6,
      ACT_FOCUS_FAR  = 4'd7,
      ACT_FOCUS_STOP = 4'd8,
      ACT_IRIS_UP    = 4'd9,
      ACT_IRIS_DOWN  = 4'd10,
      ACT_FORWARD    = 4'd11
   } action_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_ADDR,
      PH_BODY
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOUCH,
      S_ZOOM_ON,
      S_ZOOM_GO,
      S_FOCUS,
      S_IRIS,
      S_ZOOM_OFF,
      S_ZOOM_STOP,
      S_FOCUS_STOP,
      S_MOTION_OFF,
      S_PT_ON,
      S_FWD_RD,
      S_FWD_OUT
   } seq_state_type;

   // Parser to sequencer: frame complete. go and len are valid in the
   // accept cycle; the command bytes are registered and valid from the
   // following cycle until the next transaction is accepted.
   typedef struct packed {
      logic              go;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] cmd1;
      logic [BYTE_W-1:0] cmd2;
   } dispatch_type;

endpackage

@@ hdl/ptz_joystick_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ptz_joystick_frame_decoder
// Pelco-D style joystick frame parser with camera action output.
// ----------------------------------------------------------------------------
// Input channel (req_*): one serial byte per transaction, with burst_start
// marking the first byte of a receive burst (parser restarts hunting).
// Result channel (rsp_*): action/value pairs; rsp_last marks the final
// result caused by one input byte. Bytes that complete no frame give none.
// CSR port (csr_*): APB style, zoom_speed at byte address 0, pready tied
// high; write only while the decoder is idle.
// Flow: a completing byte starts the action sequencer in the following
// cycle; each non-forward result is loaded straight into the output
// register, and each forwarded frame byte is read from the frame store
// and then loaded into the output register. req_ready stays low from the
// completing byte until the last result of the frame is loaded into the
// output register; the next byte may be taken while that result waits.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the parser to hunting, the sticky flags and zoom_speed (5);
// the frame store needs no clearing, only bytes of the current frame are
// read back.
// ----------------------------------------------------------------------------
module ptz_joystick_frame_decoder
   import ptzfd_pkg::*;
#(
   parameter int MAX_FRAME = DEF_MAX_FRAME,
   parameter int MIN_FRAME = DEF_MIN_FRAME
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  req_burst_start,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [BYTE_W-1:0]     rsp_value,
   output logic                  rsp_last,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(MAX_FRAME);

   logic [BYTE_W-1:0] zoom_speed_ff, zoom_speed_in;
   logic              csr_wr, accept, seq_idle;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   dispatch_type      dispatch;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      zoom_speed_in = zoom_speed_ff;
      if (csr_wr && csr_paddr[2] == REG_ZOOM_SPEED) begin
         zoom_speed_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_speed_ff <= ZOOM_SPEED_RESET;
      end else begin
         zoom_speed_ff <= zoom_speed_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ZOOM_SPEED) ?
                       {{(CSR_DATA_W-BYTE_W){1'b0}}, zoom_speed_ff} : '0;

   // one byte at a time; held off while a frame's results drain
   assign req_ready = seq_idle;
   assign accept    = req_valid && req_ready;

   ptzfd_parser #(
      .MAX_FRAME (MAX_FRAME),
      .MIN_FRAME (MIN_FRAME),
      .AW        (AW)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .burst_start (req_burst_start),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .dispatch    (dispatch)
   );

   ptzfd_frame_mem #(
      .DEPTH (MAX_FRAME),
      .AW    (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptzfd_sequencer #(
      .AW (AW)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .dispatch   (dispatch),
      .zoom_speed (zoom_speed_ff),
      .idle       (seq_idle),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last)
   );

endmodule

@@ hdl/ptzfd_frame_mem.sv @@
// ----------------------------------------------------------------------------
// ptzfd_frame_mem
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptzfd_frame_mem
   import ptzfd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_FRAME,
   parameter int AW    = $clog2(DEF_MAX_FRAME)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ptzfd_parser.sv @@
// ----------------------------------------------------------------------------
// ptzfd_parser
// Sync hunt, running checksum and frame length; writes frame bytes to the
// store and flags a complete frame.
// ----------------------------------------------------------------------------
module ptzfd_parser
   import ptzfd_pkg::*;
#(
   parameter int MAX_FRAME = DEF_MAX_FRAME,
   parameter int MIN_FRAME = DEF_MIN_FRAME,
   parameter int AW        = $clog2(DEF_MAX_FRAME)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              burst_start,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output dispatch_type      dispatch
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FRAME);
   localparam logic [LEN_W-1:0] CMD1_IDX = LEN_W'(2);
   localparam logic [LEN_W-1:0] CMD2_IDX = LEN_W'(3);

   phase_type         phase_ff, phase_in, phase_eff;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  len_ff, len_in, len_next;
   logic [BYTE_W-1:0] cmd1_ff, cmd1_in, cmd2_ff, cmd2_in;
   logic              done;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
      end
   end

   // command bytes
   always_ff @(posedge clock) begin
      cmd1_ff <= cmd1_in;
      cmd2_ff <= cmd2_in;
   end

   // next state, store write and frame completion
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      cmd1_in   = cmd1_ff;
      cmd2_in   = cmd2_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rx_byte;
      done      = 1'b0;
      len_next  = len_ff + LEN_W'(1);

      // burst start and overlong frames fall back to hunting
      phase_eff = burst_start ? PH_HUNT : phase_ff;
      if (phase_eff == PH_BODY && len_ff >= MAX_LEN) begin
         phase_eff = PH_HUNT;
      end

      if (accept) begin
         unique case (phase_eff)
            PH_ADDR: begin
               wr_en    = 1'b1;
               wr_addr  = AW'(1);
               sum_in   = rx_byte;
               len_in   = LEN_W'(2);
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               wr_en   = 1'b1;
               wr_addr = len_ff[AW-1:0];
               if (len_ff == CMD1_IDX) begin
                  cmd1_in = rx_byte;
               end
               if (len_ff == CMD2_IDX) begin
                  cmd2_in = rx_byte;
               end
               if (rx_byte == sum_ff && len_next >= MIN_LEN) begin
                  done   = 1'b1;
                  sum_in = '0;
                  // a checksum of 0xFF doubles as the next sync; entry 0
                  // already holds the sync byte
                  if (rx_byte == SYNC_BYTE) begin
                     len_in   = LEN_W'(1);
                     phase_in = PH_ADDR;
                  end else begin
                     len_in   = len_next;
                     phase_in = PH_HUNT;
                  end
               end else begin
                  sum_in   = sum_ff + rx_byte;
                  len_in   = len_next;
                  phase_in = PH_BODY;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == SYNC_BYTE) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  sum_in   = '0;
                  len_in   = LEN_W'(1);
                  phase_in = PH_ADDR;
               end
            end
         endcase
      end
   end

   assign dispatch.go   = done;
   assign dispatch.len  = len_next;
   assign dispatch.cmd1 = cmd1_ff;
   assign dispatch.cmd2 = cmd2_ff;

endmodule

@@ hdl/ptzfd_sequencer.sv @@
// ----------------------------------------------------------------------------
// ptzfd_sequencer
// Turns a complete frame into its run of actions, keeps the sticky zoom,
// focus and motion flags, reads frame bytes back for forwarding and holds
// the result output register.
// ----------------------------------------------------------------------------
module ptzfd_sequencer
   import ptzfd_pkg::*;
#(
   parameter int AW = $clog2(DEF_MAX_FRAME)
) (
   input  logic              clock,
   input  logic              reset,
   input  dispatch_type      dispatch,
   input  logic [BYTE_W-1:0] zoom_speed,
   output logic              idle,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ACT_W-1:0]  rsp_action,
   output logic [BYTE_W-1:0] rsp_value,
   output logic              rsp_last
);

   seq_state_type     state_ff, state_in, nxt;
   logic              zoom_ff, zoom_in, focus_ff, focus_in, motion_ff, motion_in;
   logic [LEN_W-1:0]  len_ff, len_in, idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   action_type        act_ff, act;
   logic [BYTE_W-1:0] val_ff, val;
   logic              last_ff;
   logic              emit, load, out_free;
   logic              is_zoom, is_focus, is_iris, is_stop;
   seq_state_type     stop_first;

   // state, flags and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         zoom_ff      <= 1'b0;
         focus_ff     <= 1'b0;
         motion_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zoom_ff      <= zoom_in;
         focus_ff     <= focus_in;
         motion_ff    <= motion_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      idx_ff <= idx_in;
      if (load) begin
         act_ff  <= act;
         val_ff  <= val;
         last_ff <= (nxt == S_IDLE);
      end
   end

   // command class, same priority as the frame dispatch
   always_comb begin
      is_zoom  = dispatch.cmd2 == CMD2_ZOOM_TEL || dispatch.cmd2 == CMD2_ZOOM_WID;
      is_focus = dispatch.cmd1 == CMD1_FOC_NEAR || dispatch.cmd2 == CMD2_FOC_FAR;
      is_iris  = dispatch.cmd1 == CMD1_IRIS_UP || dispatch.cmd1 == CMD1_IRIS_DN;
      is_stop  = dispatch.cmd1 == CMD_NONE && dispatch.cmd2 == CMD_NONE;
      if (zoom_ff) begin
         stop_first = S_ZOOM_OFF;
      end else if (focus_ff) begin
         stop_first = S_FOCUS_STOP;
      end else if (motion_ff) begin
         stop_first = S_MOTION_OFF;
      end else begin
         stop_first = S_IDLE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and result selection
   always_comb begin
      state_in  = state_ff;
      zoom_in   = zoom_ff;
      focus_in  = focus_ff;
      motion_in = motion_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      nxt       = S_IDLE;
      act       = ACT_TOUCH;
      val       = '0;
      rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (dispatch.go) begin
               len_in   = dispatch.len;
               state_in = S_TOUCH;
            end
         end
         S_TOUCH: begin
            emit = 1'b1;
            if (is_zoom) begin
               nxt = S_ZOOM_ON;
            end else if (is_focus) begin
               nxt = S_FOCUS;
            end else if (is_iris) begin
               nxt = S_IRIS;
            end else if (is_stop) begin
               nxt = stop_first;
            end else begin
               nxt = (dispatch.cmd2 == CMD_NONE) ? S_PT_ON : S_FWD_RD;
            end
         end
         S_ZOOM_ON: begin
            emit = 1'b1;
            act  = ACT_OVL_ON;
            nxt  = S_ZOOM_GO;
         end
         S_ZOOM_GO: begin
            emit = 1'b1;
            act  = (dispatch.cmd2 == CMD2_ZOOM_WID) ? ACT_ZOOM_WIDE : ACT_ZOOM_TELE;
            val  = zoom_speed;
         end
         S_FOCUS: begin
            emit = 1'b1;
            act  = (dispatch.cmd2 == CMD2_FOC_FAR) ? ACT_FOCUS_FAR : ACT_FOCUS_NEAR;
         end
         S_IRIS: begin
            emit = 1'b1;
            act  = (dispatch.cmd1 == CMD1_IRIS_DN) ? ACT_IRIS_DOWN : ACT_IRIS_UP;
         end
         S_ZOOM_OFF: begin
            emit = 1'b1;
            act  = ACT_OVL_OFF;
            nxt  = S_ZOOM_STOP;
         end
         S_ZOOM_STOP: begin
            emit = 1'b1;
            act  = ACT_ZOOM_STOP;
            if (focus_ff) begin
               nxt = S_FOCUS_STOP;
            end else if (motion_ff) begin
               nxt = S_MOTION_OFF;
            end
         end
         S_FOCUS_STOP: begin
            emit = 1'b1;
            act  = ACT_FOCUS_STOP;
            if (motion_ff) begin
               nxt = S_MOTION_OFF;
            end
         end
         S_MOTION_OFF: begin
            emit = 1'b1;
            act  = ACT_OVL_OFF;
            nxt  = S_FWD_RD;
         end
         S_PT_ON: begin
            emit = 1'b1;
            act  = ACT_OVL_ON;
            nxt  = S_FWD_RD;
         end
         S_FWD_RD: begin
            rd_en    = 1'b1;
            state_in = S_FWD_OUT;
         end
         S_FWD_OUT: begin
            emit = 1'b1;
            act  = ACT_FORWARD;
            val  = rd_data;
            if (idx_ff != len_ff - LEN_W'(1)) begin
               nxt = S_FWD_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      load = emit && out_free;

      // sticky flags change as their result is loaded into the output register
      if (load) begin
         state_in = nxt;
         unique case (state_ff)
            S_TOUCH: begin
               idx_in = '0;
               if (!is_zoom && !is_focus && !is_iris && !is_stop) begin
                  motion_in = 1'b1;
               end
            end
            S_ZOOM_GO:    zoom_in   = 1'b1;
            S_FOCUS:      focus_in  = 1'b1;
            S_ZOOM_STOP:  zoom_in   = 1'b0;
            S_FOCUS_STOP: focus_in  = 1'b0;
            S_MOTION_OFF: motion_in = 1'b0;
            S_FWD_OUT:    idx_in    = idx_ff + LEN_W'(1);
            default: begin
            end
         endcase
      end
   end

   // output register
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   assign idle       = (state_ff == S_IDLE);
   assign rd_addr    = idx_ff[AW-1:0];
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = act_ff;
   assign rsp_value  = val_ff;
   assign rsp_last   = last_ff;

endmodule
